// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

// ===== src/mpfde_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfde_pkg
// Shared types, screen geometry and the 5x7 font table of the draw engine.
// ----------------------------------------------------------------------------
package mpfde_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int STORE_DEPTH   = 1024;
	localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;
	localparam int READ_LIMIT    = (STORE_DEPTH < SCREEN_WIDTH * PAGES) ?
		STORE_DEPTH : SCREEN_WIDTH * PAGES;
	localparam int AW            = 10;
	localparam int PG_W          = $clog2(PAGES + 1);
	localparam int FA_W          = $clog2(SCREEN_WIDTH * PAGES + STORE_DEPTH);
	localparam int GLYPH_COLS    = 5;
	localparam logic [7:0] GLYPH_FIRST = 8'h20;
	localparam logic [7:0] GLYPH_LAST  = 8'h7E;

	typedef enum logic [2:0] {
		OP_CLEAR, OP_CHAR, OP_HLINE, OP_OUTLINE, OP_FILL, OP_INVERT, OP_READ, OP_NONE
	} op_t;

	typedef enum logic [1:0] {K_CLEAR, K_DRAW, K_READ, K_NOP} kind_t;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_SEG, ST_RD, ST_WR, ST_RDB, ST_RDW, ST_DONE
	} back_state_t;

	// Clipped, inclusive pixel box
	typedef struct packed {
		logic       en;
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] y0;
		logic [7:0] y1;
	} region_t;

	typedef struct packed {
		kind_t                         kind;
		logic                          flip;
		logic                          glyph;
		logic [GLYPH_COLS-1:0][7:0]    cols;
		region_t [3:0]                 seg;
		logic [AW-1:0]                 addr;
	} cmd_t;

	typedef struct packed {
		logic       done;
		logic       is_read;
		logic [7:0] data;
	} res_t;

	// Printable ASCII font, leftmost column in the top byte
	localparam logic [4:0][7:0] GLYPH_ROM [95] = '{
		{8'h00,8'h00,8'h00,8'h00,8'h00},{8'h00,8'h00,8'h5F,8'h00,8'h00},
		{8'h00,8'h07,8'h00,8'h07,8'h00},{8'h14,8'h7F,8'h14,8'h7F,8'h14},
		{8'h24,8'h2A,8'h7F,8'h2A,8'h12},{8'h23,8'h13,8'h08,8'h64,8'h62},
		{8'h36,8'h49,8'h55,8'h22,8'h50},{8'h00,8'h05,8'h03,8'h00,8'h00},
		{8'h00,8'h1C,8'h22,8'h41,8'h00},{8'h00,8'h41,8'h22,8'h1C,8'h00},
		{8'h14,8'h08,8'h3E,8'h08,8'h14},{8'h08,8'h08,8'h3E,8'h08,8'h08},
		{8'h00,8'h50,8'h30,8'h00,8'h00},{8'h08,8'h08,8'h08,8'h08,8'h08},
		{8'h00,8'h60,8'h60,8'h00,8'h00},{8'h20,8'h10,8'h08,8'h04,8'h02},
		{8'h3E,8'h51,8'h49,8'h45,8'h3E},{8'h00,8'h42,8'h7F,8'h40,8'h00},
		{8'h42,8'h61,8'h51,8'h49,8'h46},{8'h21,8'h41,8'h45,8'h4B,8'h31},
		{8'h18,8'h14,8'h12,8'h7F,8'h10},{8'h27,8'h45,8'h45,8'h45,8'h39},
		{8'h3C,8'h4A,8'h49,8'h49,8'h30},{8'h01,8'h71,8'h09,8'h05,8'h03},
		{8'h36,8'h49,8'h49,8'h49,8'h36},{8'h06,8'h49,8'h49,8'h29,8'h1E},
		{8'h00,8'h36,8'h36,8'h00,8'h00},{8'h00,8'h56,8'h36,8'h00,8'h00},
		{8'h08,8'h14,8'h22,8'h41,8'h00},{8'h14,8'h14,8'h14,8'h14,8'h14},
		{8'h00,8'h41,8'h22,8'h14,8'h08},{8'h02,8'h01,8'h51,8'h09,8'h06},
		{8'h32,8'h49,8'h79,8'h41,8'h3E},{8'h7E,8'h11,8'h11,8'h11,8'h7E},
		{8'h7F,8'h49,8'h49,8'h49,8'h36},{8'h3E,8'h41,8'h41,8'h41,8'h22},
		{8'h7F,8'h41,8'h41,8'h22,8'h1C},{8'h7F,8'h49,8'h49,8'h49,8'h41},
		{8'h7F,8'h09,8'h09,8'h09,8'h01},{8'h3E,8'h41,8'h49,8'h49,8'h7A},
		{8'h7F,8'h08,8'h08,8'h08,8'h7F},{8'h00,8'h41,8'h7F,8'h41,8'h00},
		{8'h20,8'h40,8'h41,8'h3F,8'h01},{8'h7F,8'h08,8'h14,8'h22,8'h41},
		{8'h7F,8'h40,8'h40,8'h40,8'h40},{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
		{8'h7F,8'h04,8'h08,8'h10,8'h7F},{8'h3E,8'h41,8'h41,8'h41,8'h3E},
		{8'h7F,8'h09,8'h09,8'h09,8'h06},{8'h3E,8'h41,8'h51,8'h21,8'h5E},
		{8'h7F,8'h09,8'h19,8'h29,8'h46},{8'h46,8'h49,8'h49,8'h49,8'h31},
		{8'h01,8'h01,8'h7F,8'h01,8'h01},{8'h3F,8'h40,8'h40,8'h40,8'h3F},
		{8'h1F,8'h20,8'h40,8'h20,8'h1F},{8'h3F,8'h40,8'h38,8'h40,8'h3F},
		{8'h63,8'h14,8'h08,8'h14,8'h63},{8'h07,8'h08,8'h70,8'h08,8'h07},
		{8'h61,8'h51,8'h49,8'h45,8'h43},{8'h00,8'h7F,8'h41,8'h41,8'h00},
		{8'h02,8'h04,8'h08,8'h10,8'h20},{8'h00,8'h41,8'h41,8'h7F,8'h00},
		{8'h04,8'h02,8'h01,8'h02,8'h04},{8'h40,8'h40,8'h40,8'h40,8'h40},
		{8'h00,8'h01,8'h02,8'h04,8'h00},{8'h20,8'h54,8'h54,8'h54,8'h78},
		{8'h7F,8'h48,8'h44,8'h44,8'h38},{8'h38,8'h44,8'h44,8'h44,8'h20},
		{8'h38,8'h44,8'h44,8'h48,8'h7F},{8'h38,8'h54,8'h54,8'h54,8'h18},
		{8'h08,8'h7E,8'h09,8'h01,8'h02},{8'h0C,8'h52,8'h52,8'h52,8'h3E},
		{8'h7F,8'h08,8'h04,8'h04,8'h78},{8'h00,8'h44,8'h7D,8'h40,8'h00},
		{8'h20,8'h40,8'h44,8'h3D,8'h00},{8'h7F,8'h10,8'h28,8'h44,8'h00},
		{8'h00,8'h41,8'h7F,8'h40,8'h00},{8'h7C,8'h04,8'h18,8'h04,8'h78},
		{8'h7C,8'h08,8'h04,8'h04,8'h78},{8'h38,8'h44,8'h44,8'h44,8'h38},
		{8'h7C,8'h14,8'h14,8'h14,8'h08},{8'h08,8'h14,8'h14,8'h18,8'h7C},
		{8'h7C,8'h08,8'h04,8'h04,8'h08},{8'h48,8'h54,8'h54,8'h54,8'h20},
		{8'h04,8'h3F,8'h44,8'h40,8'h20},{8'h3C,8'h40,8'h40,8'h20,8'h7C},
		{8'h1C,8'h20,8'h40,8'h20,8'h1C},{8'h3C,8'h40,8'h30,8'h40,8'h3C},
		{8'h44,8'h28,8'h10,8'h28,8'h44},{8'h0C,8'h50,8'h50,8'h50,8'h3C},
		{8'h44,8'h64,8'h54,8'h4C,8'h44},{8'h00,8'h08,8'h36,8'h41,8'h00},
		{8'h00,8'h00,8'h7F,8'h00,8'h00},{8'h00,8'h41,8'h36,8'h08,8'h00},
		{8'h10,8'h08,8'h08,8'h10,8'h08}
	};

endpackage

// ===== src/mono_page_framebuffer_draw_engine_core.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_engine_core
// Command-driven drawing engine for a page-layout monochrome frame store.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a clock edge with start high and busy low.
//   The decoder clips it and drops it into a two-entry queue; the sequencer
//   then runs it on the 1024-byte frame store and returns exactly one result
//   word, shown for one cycle with done high (read_data/is_read valid then).
//   The receiver cannot stall; results come in command order.
// Steps: an unused op goes straight to its result; a read looks up the
//   byte on the registered read port and returns it; a clear writes zero
//   to every byte of the store; a drawing command scans its four box
//   slots and reads each column-page byte of every enabled box, writing it
//   back only when the box or glyph touches some of its pixels, else
//   skipping it.
// Reset: all control clears and a clearing pass zeroes every byte of the
//   store; busy stays high until it finishes. busy is also high while the
//   queue holds two commands.
module mono_page_framebuffer_draw_engine_core
	import mpfde_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    op,
	input  logic [7:0]    pos_x,
	input  logic [7:0]    pos_y,
	input  logic [7:0]    box_width,
	input  logic [7:0]    box_height,
	input  logic [7:0]    char_code,
	input  logic [9:0]    byte_addr,
	output logic          done,
	output logic [7:0]    read_data,
	output logic          is_read
);

	logic push, q_valid, q_full, pop, init_busy;
	cmd_t cmd, head;
	res_t res;

	assign busy      = q_full || init_busy;
	assign done      = res.done;
	assign read_data = res.data;
	assign is_read   = res.is_read;

	mpfde_front u_front (
		.start      (start),
		.busy       (busy),
		.op         (op),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.box_width  (box_width),
		.box_height (box_height),
		.char_code  (char_code),
		.byte_addr  (byte_addr),
		.push       (push),
		.cmd        (cmd)
	);

	mpfde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.valid    (q_valid),
		.full     (q_full),
		.head     (head)
	);

	mpfde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (head),
		.pop       (pop),
		.init_busy (init_busy),
		.res       (res)
	);

endmodule

// ===== src/mpfde_front.sv =====
// ----------------------------------------------------------------------------
// mpfde_front
// Decodes a command word into a kind and up to four clipped boxes.
// ----------------------------------------------------------------------------
module mpfde_front
	import mpfde_pkg::*;
(
	input  logic            start,
	input  logic            busy,
	input  logic [2:0]      op,
	input  logic [7:0]      pos_x,
	input  logic [7:0]      pos_y,
	input  logic [7:0]      box_width,
	input  logic [7:0]      box_height,
	input  logic [7:0]      char_code,
	input  logic [AW-1:0]   byte_addr,
	output logic            push,
	output cmd_t            cmd
);

	localparam logic [8:0] XMAX = 9'(SCREEN_WIDTH - 1);
	localparam logic [8:0] YMAX = 9'(SCREEN_HEIGHT - 1);

	// Clip a box at the right and bottom edges
	function automatic region_t clip(input logic en, input logic [8:0] xs,
		input logic [8:0] ys, input logic [8:0] xe, input logic [8:0] ye);
		region_t r;
		r.en = en && (xs <= XMAX) && (ys <= YMAX);
		r.x0 = xs[7:0];
		r.y0 = ys[7:0];
		r.x1 = (xe > XMAX) ? XMAX[7:0] : xe[7:0];
		r.y1 = (ye > YMAX) ? YMAX[7:0] : ye[7:0];
		return r;
	endfunction

	logic [8:0] x9, y9, xe9, ye9;
	logic       box_ok, printable;
	logic [6:0] gi;
	op_t        opc;

	assign push      = start && !busy;
	assign opc       = op_t'(op);
	assign x9        = {1'b0, pos_x};
	assign y9        = {1'b0, pos_y};
	assign xe9       = x9 + {1'b0, box_width} - 9'd1;
	assign ye9       = y9 + {1'b0, box_height} - 9'd1;
	assign box_ok    = (box_width != 8'd0) && (box_height != 8'd0);
	assign printable = (char_code >= GLYPH_FIRST) && (char_code <= GLYPH_LAST);
	assign gi        = printable ? 7'(char_code - GLYPH_FIRST) : 7'd0;

	// Classify the word and build its boxes
	always_comb begin
		cmd       = '0;
		cmd.kind  = K_NOP;
		cmd.addr  = byte_addr;
		for (int c = 0; c < GLYPH_COLS; c++) begin
			cmd.cols[c] = GLYPH_ROM[gi][GLYPH_COLS-1-c] & 8'h7F;
		end
		unique case (opc)
			OP_CLEAR: cmd.kind = K_CLEAR;
			OP_CHAR: begin
				cmd.kind   = K_DRAW;
				cmd.glyph  = 1'b1;
				cmd.seg[0] = clip(printable, x9, y9, x9 + 9'd4, y9 + 9'd6);
			end
			OP_HLINE: begin
				cmd.kind   = K_DRAW;
				cmd.seg[0] = clip(1'b1, 9'd0, y9, XMAX, y9);
			end
			OP_OUTLINE: begin
				cmd.kind   = K_DRAW;
				cmd.seg[0] = clip(box_ok, x9, y9, xe9, y9);
				cmd.seg[1] = clip(box_ok, x9, ye9, xe9, ye9);
				cmd.seg[2] = clip(box_ok, x9, y9, x9, ye9);
				cmd.seg[3] = clip(box_ok, xe9, y9, xe9, ye9);
			end
			OP_FILL: begin
				cmd.kind   = K_DRAW;
				cmd.seg[0] = clip(box_ok, x9, y9, xe9, ye9);
			end
			OP_INVERT: begin
				cmd.kind   = K_DRAW;
				cmd.flip   = 1'b1;
				cmd.seg[0] = clip(box_ok, x9, y9, xe9, ye9);
			end
			OP_READ: cmd.kind = K_READ;
			OP_NONE: cmd.kind = K_NOP;
			default: cmd.kind = K_NOP;
		endcase
	end

endmodule

// ===== src/mpfde_queue.sv =====
// ----------------------------------------------------------------------------
// mpfde_queue
// Two-entry command queue between the decoder and the draw sequencer.
// ----------------------------------------------------------------------------
module mpfde_queue
	import mpfde_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic valid,
	output logic full,
	output cmd_t head
);

	cmd_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = slot_q[rp_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Hold the payload
	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_cmd;
	end

endmodule

// ===== src/mpfde_back.sv =====
// ----------------------------------------------------------------------------
// mpfde_back
// Draw sequencer: owns the frame store, clears it, serves byte reads and
// walks each box byte by byte with a read-modify-write.
// ----------------------------------------------------------------------------
module mpfde_back
	import mpfde_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic pop,
	output logic init_busy,
	output res_t res
);

	logic [7:0]    mem [STORE_DEPTH];
	logic [7:0]    rd_q;
	logic          we;
	logic [AW-1:0] wa, ra;
	logic [7:0]    wd;

	back_state_t   state_q, state_d;
	cmd_t          cmd_q;
	logic [1:0]    seg_q, seg_d;
	logic [7:0]    cx_q, cx_d;
	logic [PG_W-1:0] cp_q, cp_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [7:0]    mask_q, mask_d;

	region_t       r;
	logic [FA_W-1:0] fa;
	logic          fa_ok;
	logic [7:0]    rmask, gbyte, mask;
	logic [2:0]    gidx;
	logic [15:0]   gsh;
	logic [4:0]    pd;
	logic [8:0]    row;
	logic          last_x, last_p;

	assign r     = cmd_q.seg[seg_q];
	assign fa    = FA_W'(cp_q) * FA_W'(SCREEN_WIDTH) + FA_W'(cx_q);
	assign fa_ok = fa < FA_W'(STORE_DEPTH);
	assign gidx  = 3'(cx_q - r.x0);
	assign gsh   = {8'd0, cmd_q.cols[gidx]} << r.y0[2:0];
	assign pd    = 5'(cp_q) - r.y0[7:3];
	assign gbyte = (pd == 5'd0) ? gsh[7:0] : gsh[15:8];
	assign mask  = rmask & (cmd_q.glyph ? gbyte : 8'hFF);
	assign last_x = (cx_q == r.x1);
	assign last_p = (cp_q == PG_W'(r.y1[7:3]));
	assign init_busy = (state_q == ST_INIT);

	// Rows of the current page inside the box
	always_comb begin
		rmask = '0;
		row   = '0;
		for (int b = 0; b < 8; b++) begin
			row      = 9'({cp_q, 3'(b)});
			rmask[b] = (row >= {1'b0, r.y0}) && (row <= {1'b0, r.y1});
		end
	end

	// Frame store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			seg_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= q_cmd;
		cx_q   <= cx_d;
		cp_q   <= cp_d;
		addr_q <= addr_d;
		mask_q <= mask_d;
	end

	// Sequencer: next state, store port and result
	always_comb begin
		state_d = state_q;
		seg_d   = seg_q;
		cx_d    = cx_q;
		cp_d    = cp_q;
		clr_d   = clr_q;
		addr_d  = addr_q;
		mask_d  = mask_q;
		pop     = 1'b0;
		we      = 1'b0;
		wa      = clr_q;
		wd      = 8'd0;
		ra      = fa[AW-1:0];
		res     = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				we    = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == AW'(STORE_DEPTH - 1)) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					pop   = 1'b1;
					seg_d = '0;
					clr_d = '0;
					unique case (q_cmd.kind)
						K_CLEAR: state_d = ST_CLEAR;
						K_DRAW:  state_d = ST_SEG;
						K_READ:  state_d = ST_RDB;
						K_NOP:   state_d = ST_DONE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SEG: begin
				if (r.en) begin
					cx_d    = r.x0;
					cp_d    = PG_W'(r.y0[7:3]);
					state_d = ST_RD;
				end else if (seg_q == 2'd3) begin
					state_d = ST_DONE;
				end else begin
					seg_d = seg_q + 2'd1;
				end
			end
			ST_RD, ST_WR: begin
				if (state_q == ST_WR) begin
					we = 1'b1;
					wa = addr_q;
					wd = cmd_q.flip ? (rd_q ^ mask_q) : (rd_q | mask_q);
				end
				if (state_q == ST_RD && fa_ok && mask != 8'd0) begin
					addr_d  = fa[AW-1:0];
					mask_d  = mask;
					state_d = ST_WR;
				end else if (!last_x) begin
					cx_d    = cx_q + 8'd1;
					state_d = ST_RD;
				end else if (!last_p) begin
					cx_d    = r.x0;
					cp_d    = cp_q + 1'b1;
					state_d = ST_RD;
				end else if (seg_q == 2'd3) begin
					state_d = ST_DONE;
				end else begin
					seg_d   = seg_q + 2'd1;
					state_d = ST_SEG;
				end
			end
			ST_RDB: begin
				ra      = cmd_q.addr;
				state_d = ST_RDW;
			end
			ST_RDW: begin
				res.done    = 1'b1;
				res.is_read = 1'b1;
				res.data    = ({1'b0, cmd_q.addr} < (AW+1)'(READ_LIMIT)) ? rd_q : 8'd0;
				state_d     = ST_IDLE;
			end
			ST_DONE: begin
				res.done = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/mpfde_checker.sv =====
// ----------------------------------------------------------------------------
// mpfde_checker
// Port-level checks of the draw engine's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpfde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       done,
	input logic [7:0] read_data,
	input logic       is_read
);

	// Result fields stay quiet between result words
	`ASSERT_IMP(a_idle_quiet, clk, arst_n, !done, (read_data == 8'd0) && !is_read)
	// Nonzero data only comes with a read result
	`ASSERT_IMP(a_data_read, clk, arst_n, read_data != 8'd0, is_read && done)
	// The sequencer returns to idle after every result, so results never abut
	`ASSERT_NXT(a_done_gap, clk, arst_n, done, !done)

endmodule

bind mono_page_framebuffer_draw_engine_core mpfde_checker u_mpfde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.done      (done),
	.read_data (read_data),
	.is_read   (is_read)
);

// ===== test/mono_page_framebuffer_draw_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_engine_core_tb
// Drives all command kinds into the draw engine and checks every
// result word against a pixel-level shadow of the frame store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mono_page_framebuffer_draw_engine_core_tb;
	import mpfde_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		op_t        op;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] w;
		logic [7:0] h;
		logic [7:0] code;
		logic [9:0] addr;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic       rd;
	} readback_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, is_read;
	logic [2:0] op = '0;
	logic [7:0] pos_x = '0, pos_y = '0, box_width = '0, box_height = '0, char_code = '0;
	logic [9:0] byte_addr = '0;
	logic [7:0] read_data;

	draw_cmd_t cmd_q[$];
	readback_t readback_q[$];
	logic [7:0] shadow_fb[STORE_DEPTH];
	logic taken = 1'b0;
	int gap_left = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	bit stim_done = 0;

	mono_page_framebuffer_draw_engine_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.pos_x(pos_x), .pos_y(pos_y), .box_width(box_width), .box_height(box_height),
		.char_code(char_code), .byte_addr(byte_addr), .done(done),
		.read_data(read_data), .is_read(is_read)
	);

	always #5 clk = ~clk;

	// Set or flip one pixel of the shadow store, dropping anything off screen
	function automatic void plot(int px, int py, bit flip);
		int idx;
		if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
			return;
		idx = (py / 8) * SCREEN_WIDTH + px;
		if (idx >= STORE_DEPTH)
			return;
		if (flip)
			shadow_fb[idx] ^= 8'(1 << (py % 8));
		else
			shadow_fb[idx] |= 8'(1 << (py % 8));
	endfunction

	// Apply one command to the shadow store and return its result word
	function automatic readback_t render(draw_cmd_t c);
		readback_t r;
		logic [7:0] bits;
		r.data = '0;
		r.rd = 1'b0;
		case (c.op)
			OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
			OP_CHAR: begin
				if (c.code >= GLYPH_FIRST && c.code <= GLYPH_LAST)
					for (int col = 0; col < GLYPH_COLS; col++) begin
						bits = GLYPH_ROM[c.code - GLYPH_FIRST][GLYPH_COLS - 1 - col];
						for (int row = 0; row < 7; row++)
							if (bits[row])
								plot(c.x + col, c.y + row, 0);
					end
			end
			OP_HLINE: for (int px = 0; px < SCREEN_WIDTH; px++) plot(px, c.y, 0);
			OP_OUTLINE: begin
				if (c.w != 0 && c.h != 0) begin
					for (int i = 0; i < c.w; i++) begin
						plot(c.x + i, c.y, 0);
						plot(c.x + i, c.y + c.h - 1, 0);
					end
					for (int i = 0; i < c.h; i++) begin
						plot(c.x, c.y + i, 0);
						plot(c.x + c.w - 1, c.y + i, 0);
					end
				end
			end
			OP_FILL, OP_INVERT: begin
				for (int row = 0; row < c.h; row++)
					for (int col = 0; col < c.w; col++)
						plot(c.x + col, c.y + row, c.op == OP_INVERT);
			end
			OP_READ: begin
				r.rd = 1'b1;
				if (c.addr < READ_LIMIT)
					r.data = shadow_fb[c.addr];
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic draw_cmd_t mk(op_t o, int x, int y, int w, int h, int code, int addr);
		draw_cmd_t c;
		c.op = o;
		c.x = 8'(x);
		c.y = 8'(y);
		c.w = 8'(w);
		c.h = 8'(h);
		c.code = 8'(code);
		c.addr = 10'(addr);
		return c;
	endfunction

	// Random command: mostly small boxes near the screen, some full-range noise
	function automatic draw_cmd_t rand_cmd();
		draw_cmd_t c;
		int sel;
		sel = $urandom_range(0, 99);
		c = mk(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1023));
		if (sel < 35) c.op = OP_READ;
		else if (sel < 57) c.op = OP_CHAR;
		else if (sel < 62) c.op = OP_HLINE;
		else if (sel < 73) c.op = OP_OUTLINE;
		else if (sel < 84) c.op = OP_FILL;
		else if (sel < 95) c.op = OP_INVERT;
		else if (sel < 98) c.op = OP_NONE;
		else c.op = OP_CLEAR;
		if ($urandom_range(0, 9) != 0) begin
			c.x = 8'($urandom_range(0, 135));
			c.y = 8'($urandom_range(0, 70));
			c.w = 8'($urandom_range(0, 16));
			c.h = 8'($urandom_range(0, 16));
			if ($urandom_range(0, 4) != 0)
				c.code = 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
		end
		return c;
	endfunction

	// Fill the command queue, then wait for the drain
	initial begin
		cmd_q.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_CHAR, 0, 0, 0, 0, 8'h41, 0));
		cmd_q.push_back(mk(OP_CHAR, 124, 60, 0, 0, 8'h7E, 0));
		cmd_q.push_back(mk(OP_CHAR, 10, 10, 0, 0, 8'h1F, 0));
		cmd_q.push_back(mk(OP_CHAR, 20, 10, 0, 0, 8'h7F, 0));
		cmd_q.push_back(mk(OP_CHAR, 255, 255, 0, 0, 8'hFF, 0));
		cmd_q.push_back(mk(OP_CHAR, 30, 10, 0, 0, 8'h20, 0));
		cmd_q.push_back(mk(OP_HLINE, 0, 63, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_HLINE, 0, 64, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_HLINE, 255, 255, 255, 255, 255, 1023));
		cmd_q.push_back(mk(OP_OUTLINE, 5, 5, 0, 9, 0, 0));
		cmd_q.push_back(mk(OP_OUTLINE, 5, 5, 9, 0, 0, 0));
		cmd_q.push_back(mk(OP_OUTLINE, 40, 20, 1, 1, 0, 0));
		cmd_q.push_back(mk(OP_OUTLINE, 100, 40, 255, 255, 0, 0));
		cmd_q.push_back(mk(OP_FILL, 60, 30, 3, 12, 0, 0));
		cmd_q.push_back(mk(OP_INVERT, 0, 0, 255, 255, 0, 0));
		cmd_q.push_back(mk(OP_INVERT, 61, 31, 4, 4, 0, 0));
		cmd_q.push_back(mk(OP_NONE, 255, 255, 255, 255, 255, 1023));
		for (int i = 0; i < 8; i++)
			cmd_q.push_back(mk(OP_READ, 0, 0, 0, 0, 0, (i == 0) ? 1023 : $urandom_range(0, 1023)));
		cmd_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 127));
		for (int i = 0; i < 1725; i++)
			cmd_q.push_back(rand_cmd());
		wait (cmd_q.size() == 0 && !start);
		wait (readback_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Release reset once, on a falling clock edge
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Driver: present words in bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				draw_cmd_t c;
				c = cmd_q.pop_front();
				op <= c.op;
				pos_x <= c.x;
				pos_y <= c.y;
				box_width <= c.w;
				box_height <= c.h;
				char_code <= c.code;
				byte_addr <= c.addr;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predict on accepted words, check every result word
	always @(posedge clk) begin
		taken <= start && !busy && arst_n;
		if (arst_n) begin
			if (done) begin
				if (readback_q.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					readback_t e;
					e = readback_q.pop_front();
					if (read_data !== e.data) begin
						$error("read_data expected %0h actual %0h", e.data, read_data);
						errors++;
					end
					if (is_read !== e.rd) begin
						$error("is_read expected %0h actual %0h", e.rd, is_read);
						errors++;
					end
				end
			end
			if (start && !busy)
				readback_q.push_back(render(mk(op_t'(op), pos_x, pos_y, box_width, box_height,
					char_code, byte_addr)));
			// Watchdog on cycles with no handshake at all
			if (done || (start && !busy) || (readback_q.size() == 0 && !start))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial foreach (shadow_fb[i]) shadow_fb[i] = '0;

endmodule

// ===== sim.f =====
+incdir+src
src/mpfde_pkg.sv
src/mpfde_front.sv
src/mpfde_queue.sv
src/mpfde_back.sv
src/mono_page_framebuffer_draw_engine_core.sv
src/mpfde_checker.sv
test/mono_page_framebuffer_draw_engine_core_tb.sv
